>>> hw/rtl/b64e_pkg.sv
`default_nettype none

package b64e_pkg;

   // depth of the job queue between front and back
   localparam int QDEPTH = 4;
   localparam int QPTR_W = $clog2(QDEPTH);
   localparam int QCNT_W = $clog2(QDEPTH + 1);

   localparam logic [6:0] PAD_CHAR = 7'h3d;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
   } req_item_type;

   typedef struct packed {
      logic [6:0] out_char;
      logic       end_of_text;
   } rsp_item_type;

   // characters of one job: index 0 is sym0, index 1 is sym1, any later one is padding
   typedef struct packed {
      logic [5:0] sym0;
      logic [5:0] sym1;
      logic [1:0] cnt_m1;
      logic       last;
   } job_type;

   function automatic logic [6:0] sym_to_ascii(input logic [5:0] v);
      logic [6:0] v7;
      logic [6:0] ch;
      v7 = {1'b0, v};
      if (v < 6'd26) begin
         ch = v7 + 7'd65;
      end else if (v < 6'd52) begin
         ch = v7 + 7'd71;
      end else if (v < 6'd62) begin
         ch = v7 - 7'd4;
      end else if (v == 6'd62) begin
         ch = 7'd43;
      end else begin
         ch = 7'd47;
      end
      return ch;
   endfunction

endpackage

`default_nettype wire

>>> hw/rtl/b64e_front.sv
`default_nettype none

module b64e_front
   import b64e_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   input  wire req_item_type req_item,
   input  wire logic         q_full,
   output      logic         job_push,
   output      job_type      job
);

   localparam logic [1:0] PH_START = 2'd0;
   localparam logic [1:0] PH_ONE   = 2'd1;
   localparam logic [1:0] PH_TWO   = 2'd2;

   logic [1:0] phase_ff, phase_in;
   logic [5:0] carry_ff, carry_in;
   logic [7:0] b;

   assign b        = req_item.data_byte;
   assign job_push = req_push && !q_full;

   always_comb begin
      job.last = req_item.last_byte;
      case (phase_ff)
         PH_ONE: begin
            job.sym0   = carry_ff | {2'b00, b[7:4]};
            job.sym1   = {b[3:0], 2'b00};
            job.cnt_m1 = req_item.last_byte ? 2'd2 : 2'd0;
            carry_in   = {b[3:0], 2'b00};
            phase_in   = PH_TWO;
         end
         PH_TWO: begin
            job.sym0   = carry_ff | {4'b0000, b[7:6]};
            job.sym1   = b[5:0];
            job.cnt_m1 = 2'd1;
            carry_in   = 6'd0;
            phase_in   = PH_START;
         end
         default: begin
            job.sym0   = b[7:2];
            job.sym1   = {b[1:0], 4'b0000};
            job.cnt_m1 = req_item.last_byte ? 2'd3 : 2'd0;
            carry_in   = {b[1:0], 4'b0000};
            phase_in   = PH_ONE;
         end
      endcase
      // end of message starts a fresh group
      if (req_item.last_byte) begin
         carry_in = 6'd0;
         phase_in = PH_START;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_START;
         carry_ff <= 6'd0;
      end else if (job_push) begin
         phase_ff <= phase_in;
         carry_ff <= carry_in;
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/b64e_queue.sv
`default_nettype none

module b64e_queue
   import b64e_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    q_push,
   input  wire job_type q_din,
   output      logic    q_full,
   input  wire logic    q_pop,
   output      logic    q_empty,
   output      job_type q_head
);

   job_type             entry_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff;
   logic                do_push, do_pop;

   assign q_full  = (count_ff == QCNT_W'(QDEPTH));
   assign q_empty = (count_ff == '0);
   assign q_head  = entry_ff[rd_ptr_ff];
   assign do_push = q_push && !q_full;
   assign do_pop  = q_pop && !q_empty;

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_din;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

`default_nettype wire

>>> hw/rtl/b64e_back.sv
`default_nettype none

module b64e_back
   import b64e_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         q_empty,
   input  wire job_type      q_head,
   output      logic         q_pop,
   output      logic         rsp_empty,
   input  wire logic         rsp_pop,
   output      rsp_item_type rsp_item
);

   logic [1:0]   idx_ff, idx_in;
   logic         out_valid_ff;
   rsp_item_type out_item_ff, out_item_in;
   logic         load;
   logic         at_end;

   // output register takes a new character when empty or being drained
   assign load   = !q_empty && (!out_valid_ff || rsp_pop);
   assign at_end = (idx_ff == q_head.cnt_m1);
   assign q_pop  = load && at_end;
   assign idx_in = at_end ? 2'd0 : idx_ff + 2'd1;

   always_comb begin
      case (idx_ff)
         2'd0:    out_item_in.out_char = sym_to_ascii(q_head.sym0);
         2'd1:    out_item_in.out_char = sym_to_ascii(q_head.sym1);
         default: out_item_in.out_char = PAD_CHAR;
      endcase
      out_item_in.end_of_text = q_head.last && at_end;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         out_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff       <= idx_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_pop) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         out_item_ff <= out_item_in;
      end
   end

   assign rsp_empty = !out_valid_ff;
   assign rsp_item  = out_item_ff;

endmodule

`default_nettype wire

>>> hw/rtl/base64_stream_encoder.sv
// path: accepted byte -> job queue -> output register, one character at a time
// throughput: one character per cycle out of the single output register while jobs
//   wait and the reader pops; a byte gives 1 to 4 characters (1 or 2 inside a
//   message, 2 to 4 on the last byte), 4 characters per 3-byte group on a long message
// reset (synchronous, active high) clears group phase, carried bits, job queue
//   and output register; the block is ready in the cycle after reset
`default_nettype none

module base64_stream_encoder
   import b64e_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_push,
   output      logic         req_full,
   input  wire req_item_type req_item,
   output      logic         rsp_empty,
   input  wire logic         rsp_pop,
   output      rsp_item_type rsp_item
);

   logic    job_push;
   job_type job;
   logic    q_full, q_empty, q_pop;
   job_type q_head;

   assign req_full = q_full;

   b64e_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_item (req_item),
      .q_full   (q_full),
      .job_push (job_push),
      .job      (job)
   );

   b64e_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .q_push  (job_push),
      .q_din   (job),
      .q_full  (q_full),
      .q_pop   (q_pop),
      .q_empty (q_empty),
      .q_head  (q_head)
   );

   b64e_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire

>>> hw/rtl/b64e_checker.sv
`default_nettype none

module b64e_checker
   import b64e_pkg::*;
(
   input wire logic         clock,
   input wire logic         reset,
   input wire logic         req_push,
   input wire logic         req_full,
   input wire logic         rsp_empty,
   input wire logic         rsp_pop,
   input wire rsp_item_type rsp_item
);

   a_reset_empty: assert property (@(posedge clock) reset |=> rsp_empty)
      else $error("result side not empty after reset");

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_full)
      else $error("input side full after reset");

   // once an accepted byte has passed the job queue and the output register, a character is always waiting
   a_item_reaches_out: assert property (@(posedge clock) disable iff (reset)
      (req_push && !req_full) |=> ##1 !rsp_empty)
      else $error("accepted item produced no character");

   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_item)))
      else $error("waiting character changed or vanished");

endmodule

bind base64_stream_encoder b64e_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_push  (req_push),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_item  (rsp_item)
);

`default_nettype wire

>>> tb/base64_checker.sv
`timescale 1ns / 1ps

module base64_checker
   import b64e_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_push,
   input  logic         req_full,
   input  req_item_type req_item,
   input  logic         rsp_empty,
   input  logic         rsp_pop,
   input  rsp_item_type rsp_item,
   output int           error_count,
   output int           chars_owed
);

   localparam logic [1:0] PHASE_FIRST  = 2'd0;
   localparam logic [1:0] PHASE_SECOND = 2'd1;
   localparam logic [1:0] PHASE_THIRD  = 2'd2;
   localparam logic [6:0] EQUALS_SIGN  = 7'h3d;

   localparam logic [0:63][7:0] ALPHABET =
      "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

   logic [1:0] group_phase;
   logic [7:0] carry_bits;
   rsp_item_type char_q[$];

   function automatic void queue_symbol(input logic [5:0] v);
      rsp_item_type c;
      c.out_char = ALPHABET[v][6:0];
      c.end_of_text = 1'b0;
      char_q.push_back(c);
   endfunction

   function automatic void queue_pad();
      rsp_item_type c;
      c.out_char = EQUALS_SIGN;
      c.end_of_text = 1'b0;
      char_q.push_back(c);
   endfunction

   // work out the characters caused by one byte and advance the group state
   function automatic void encode_byte(input req_item_type it);
      logic [7:0] b;
      b = it.data_byte;
      case (group_phase)
         PHASE_SECOND: begin
            queue_symbol(carry_bits[5:0] | {2'b00, b[7:4]});
            carry_bits = {2'b00, b[3:0], 2'b00};
            group_phase = PHASE_THIRD;
            if (it.last_byte) begin
               queue_symbol(carry_bits[5:0]);
               queue_pad();
            end
         end
         PHASE_THIRD: begin
            queue_symbol(carry_bits[5:0] | {4'b0000, b[7:6]});
            queue_symbol(b[5:0]);
            carry_bits = 8'h00;
            group_phase = PHASE_FIRST;
         end
         default: begin
            queue_symbol(b[7:2]);
            carry_bits = {2'b00, b[1:0], 4'b0000};
            group_phase = PHASE_SECOND;
            if (it.last_byte) begin
               queue_symbol(carry_bits[5:0]);
               queue_pad();
               queue_pad();
            end
         end
      endcase
      if (it.last_byte) begin
         char_q[char_q.size() - 1].end_of_text = 1'b1;
         group_phase = PHASE_FIRST;
         carry_bits = 8'h00;
      end
   endfunction

   always @(posedge clock) begin
      rsp_item_type want;
      if (reset) begin
         char_q.delete();
         group_phase = PHASE_FIRST;
         carry_bits = 8'h00;
         error_count = 0;
         chars_owed <= 0;
      end else begin
         if (req_push && !req_full) begin
            encode_byte(req_item);
         end
         if (rsp_pop && !rsp_empty) begin
            if (char_q.size() == 0) begin
               $display("%0t: unexpected item, expected none, got char %h end %b",
                        $time, rsp_item.out_char, rsp_item.end_of_text);
               error_count = error_count + 1;
            end else begin
               want = char_q.pop_front();
               if (rsp_item.out_char !== want.out_char) begin
                  $display("%0t: out_char expected %h got %h",
                           $time, want.out_char, rsp_item.out_char);
                  error_count = error_count + 1;
               end
               if (rsp_item.end_of_text !== want.end_of_text) begin
                  $display("%0t: end_of_text expected %b got %b",
                           $time, want.end_of_text, rsp_item.end_of_text);
                  error_count = error_count + 1;
               end
            end
         end
         chars_owed <= char_q.size();
      end
   end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps

module tb;
   import b64e_pkg::*;

   localparam int TOTAL_BYTES  = 280;
   localparam int IDLE_LIMIT   = 2000;
   localparam int LONG_HOLD    = 400;
   localparam int HOLD_AT_CHAR = 60;
   localparam int TAIL_CYCLES  = 16;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_push = 1'b0;
   logic         req_full;
   req_item_type req_item = '0;
   logic         rsp_empty;
   logic         rsp_pop = 1'b0;
   rsp_item_type rsp_item;

   int error_count;
   int chars_owed;
   int idle_cycles = 0;
   int bytes_sent = 0;
   bit burst_msg = 1'b0;

   always #5 clock = ~clock;

   base64_stream_encoder DUT (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

   base64_checker u_check (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_item    (req_item),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_item    (rsp_item),
      .error_count (error_count),
      .chars_owed  (chars_owed)
   );

   // watchdog on cycles where neither side moves an item
   always @(posedge clock) begin
      if (reset || (req_push && !req_full) || (rsp_pop && !rsp_empty)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("FAIL");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_byte(input logic [7:0] data, input logic last);
      int gap;
      gap = burst_msg ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_item <= '{data_byte: data, last_byte: last};
      do @(posedge clock); while (req_full);
      bytes_sent++;
   endtask

   // stop offering until every owed character has come out
   task automatic drain_wait();
      req_push <= 1'b0;
      @(posedge clock);
      while (chars_owed != 0) @(posedge clock);
   endtask

   initial begin : receiver
      int gap;
      int popped;
      int fast_left;
      popped = 0;
      fast_left = 0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (popped == HOLD_AT_CHAR) begin
            gap = LONG_HOLD;
         end else if (fast_left > 0) begin
            gap = 0;
            fast_left--;
         end else begin
            gap = $urandom_range(0, 15);
            if ($urandom_range(0, 7) == 0) fast_left = $urandom_range(8, 40);
         end
         if (gap > 0) begin
            rsp_pop <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_pop <= 1'b1;
         do @(posedge clock); while (rsp_empty);
         popped++;
      end
   end

   initial begin : stimulus
      int msg_len;
      bit paused;
      paused = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // one-byte messages: double padding
      send_byte(8'h00, 1'b1);
      send_byte(8'hff, 1'b1);
      // full groups hitting '+' and '/' and 'A'
      send_byte(8'hfb, 1'b0);
      send_byte(8'hef, 1'b0);
      send_byte(8'hbe, 1'b1);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'hff, 1'b1);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      // two-byte message: single padding
      send_byte(8'ha5, 1'b0);
      send_byte(8'h5a, 1'b1);
      // crosses a group boundary, ends mid group
      send_byte(8'h4d, 1'b0);
      send_byte(8'h61, 1'b0);
      send_byte(8'h6e, 1'b0);
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b1);
      send_byte(8'h80, 1'b1);
      send_byte(8'h01, 1'b1);
      drain_wait();

      while (bytes_sent < TOTAL_BYTES) begin
         burst_msg = ($urandom_range(0, 3) == 0);
         msg_len = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 30)
                                               : $urandom_range(1, 8);
         for (int i = 0; i < msg_len; i++) begin
            send_byte(8'($urandom_range(0, 255)), i == msg_len - 1);
         end
         if (!paused && bytes_sent >= TOTAL_BYTES / 2) begin
            paused = 1'b1;
            drain_wait();
         end
      end
      burst_msg = 1'b0;
      drain_wait();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0 && chars_owed == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
